// ===== hw/rtl/gfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// gfpe_pkg
// Shared types, constants and the GF(2^8) multiply for the parity encoder.
// ----------------------------------------------------------------------------
package gfpe_pkg;

    localparam int LANE_SHARDS = 8;
    localparam int LANE_ROWS   = 4;

    localparam int DEF_MAX_DATA_SHARDS   = 8;
    localparam int DEF_MAX_PARITY_SHARDS = 4;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0] RST_FIELD_POLY   = 8'h1D;
    localparam logic [3:0] RST_DATA_COUNT   = 4'd8;
    localparam logic [2:0] RST_PARITY_COUNT = 3'd4;

    typedef logic [7:0] t_byte;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIELD_POLY   = 8'd0,
        REG_DATA_COUNT   = 8'd1,
        REG_PARITY_COUNT = 8'd2,
        REG_ROW0_COEF    = 8'd3,
        REG_ROW1_COEF    = 8'd4,
        REG_ROW2_COEF    = 8'd5,
        REG_ROW3_COEF    = 8'd6
    } t_cfg_reg;

    function automatic t_byte gf_mul(input t_byte a_in, input t_byte b, input t_byte poly);
        t_byte acc;
        t_byte a;
        acc = '0;
        a   = a_in;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? poly : 8'h00);
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/gfpe_lane.sv =====
// ----------------------------------------------------------------------------
// gfpe_lane
// One parity row: GF(2^8) products of each shard byte and its coefficient.
// ----------------------------------------------------------------------------
module gfpe_lane #(
    parameter int P_SHARDS = gfpe_pkg::LANE_SHARDS
) (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic [gfpe_pkg::LANE_SHARDS*8-1:0]     i_stripe,
    input  logic [gfpe_pkg::LANE_SHARDS*8-1:0]     i_coef,
    input  gfpe_pkg::t_byte                        i_poly,
    input  logic [3:0]                             i_data_count,
    output gfpe_pkg::t_byte [P_SHARDS-1:0]         o_products
);

    gfpe_pkg::t_byte [P_SHARDS-1:0] n_products;
    gfpe_pkg::t_byte [P_SHARDS-1:0] r_products;

    always_comb begin
        for (int c = 0; c < P_SHARDS; c++) begin
            if (i_data_count > 4'(c)) begin
                n_products[c] = gfpe_pkg::gf_mul(i_coef[c*8 +: 8], i_stripe[c*8 +: 8], i_poly);
            end else begin
                n_products[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_products <= n_products;
        end
    end

    assign o_products = r_products;

endmodule

// ===== hw/rtl/gfpe_merge.sv =====
// ----------------------------------------------------------------------------
// gfpe_merge
// XOR-combine the lane products per row and register the parity beat.
// ----------------------------------------------------------------------------
module gfpe_merge #(
    parameter int P_SHARDS = gfpe_pkg::LANE_SHARDS,
    parameter int P_ROWS   = gfpe_pkg::LANE_ROWS
) (
    input  logic                                           i_clk,
    input  logic                                           i_load,
    input  gfpe_pkg::t_byte [P_ROWS-1:0][P_SHARDS-1:0]     i_products,
    input  logic [2:0]                                     i_parity_count,
    output logic [gfpe_pkg::LANE_ROWS*8-1:0]               o_parity
);

    logic [gfpe_pkg::LANE_ROWS*8-1:0] n_parity;
    logic [gfpe_pkg::LANE_ROWS*8-1:0] r_parity;

    always_comb begin
        n_parity = '0;
        for (int r = 0; r < P_ROWS; r++) begin
            for (int c = 0; c < P_SHARDS; c++) begin
                n_parity[r*8 +: 8] = n_parity[r*8 +: 8] ^ i_products[r][c];
            end
            if (i_parity_count <= 3'(r)) begin
                n_parity[r*8 +: 8] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_parity <= n_parity;
        end
    end

    assign o_parity = r_parity;

endmodule

// ===== hw/rtl/gf256_matrix_parity_encoder.sv =====
// ----------------------------------------------------------------------------
// gf256_matrix_parity_encoder
// Reed-Solomon style GF(2^8) matrix parity over one stripe per beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  stripe  | in        | i_valid / o_stall   | i_stripe_bytes, i_block_end
//  parity  | out       | o_valid / i_stall   | o_parity_bytes, o_block_end_out
//  config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
//  One beat per cycle unless the output stalls; product stage, then XOR merge.
//  The product stage holds one GF multiplier per shard per row.
//  Synchronous active-low reset empties both stages and loads register defaults.
//  A stall on the output backs up through both stages; input stalls only
//  when both stages hold beats and the output is stalled.
// ----------------------------------------------------------------------------
module gf256_matrix_parity_encoder #(
    parameter int MAX_DATA_SHARDS   = gfpe_pkg::DEF_MAX_DATA_SHARDS,
    parameter int MAX_PARITY_SHARDS = gfpe_pkg::DEF_MAX_PARITY_SHARDS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gfpe_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [gfpe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [63:0]                         i_stripe_bytes,
    input  logic                                i_block_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [31:0]                         o_parity_bytes,
    output logic                                o_block_end_out
);

    localparam int LANES_D = (MAX_DATA_SHARDS < gfpe_pkg::LANE_SHARDS) ?
                             MAX_DATA_SHARDS : gfpe_pkg::LANE_SHARDS;
    localparam int LANES_R = (MAX_PARITY_SHARDS < gfpe_pkg::LANE_ROWS) ?
                             MAX_PARITY_SHARDS : gfpe_pkg::LANE_ROWS;

    gfpe_pkg::t_byte                    r_poly;
    logic [3:0]                         r_data_count;
    logic [2:0]                         r_parity_count;
    logic [LANES_R-1:0][63:0]           r_coef;

    logic                               r_v1;
    logic                               r_end1;
    logic                               r_v2;
    logic                               r_end2;

    logic                               s2_ready;
    logic                               s1_ready;
    logic                               s1_load;
    logic                               s2_load;

    gfpe_pkg::t_byte [LANES_R-1:0][LANES_D-1:0] lane_products;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly         <= gfpe_pkg::RST_FIELD_POLY;
            r_data_count   <= gfpe_pkg::RST_DATA_COUNT;
            r_parity_count <= gfpe_pkg::RST_PARITY_COUNT;
            r_coef         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gfpe_pkg::REG_FIELD_POLY:   r_poly         <= i_cfg_data[7:0];
                gfpe_pkg::REG_DATA_COUNT:   r_data_count   <= i_cfg_data[3:0];
                gfpe_pkg::REG_PARITY_COUNT: r_parity_count <= i_cfg_data[2:0];
                default: begin
                    for (int r = 0; r < LANES_R; r++) begin
                        if (i_cfg_index ==
                            gfpe_pkg::CFG_INDEX_W'(int'(gfpe_pkg::REG_ROW0_COEF) + r)) begin
                            r_coef[r] <= i_cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    assign s2_ready = !r_v2 || !i_stall;
    assign s1_ready = !r_v1 || s2_ready;
    assign s1_load  = i_valid && s1_ready;
    assign s2_load  = r_v1 && s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_end1 <= i_block_end;
        end
        if (s2_load) begin
            r_end2 <= r_end1;
        end
    end

    for (genvar r = 0; r < LANES_R; r++) begin : g_row
        gfpe_lane #(
            .P_SHARDS (LANES_D)
        ) u_lane (
            .i_clk        (i_clk),
            .i_load       (s1_load),
            .i_stripe     (i_stripe_bytes),
            .i_coef       (r_coef[r]),
            .i_poly       (r_poly),
            .i_data_count (r_data_count),
            .o_products   (lane_products[r])
        );
    end

    gfpe_merge #(
        .P_SHARDS (LANES_D),
        .P_ROWS   (LANES_R)
    ) u_merge (
        .i_clk          (i_clk),
        .i_load         (s2_load),
        .i_products     (lane_products),
        .i_parity_count (r_parity_count),
        .o_parity       (o_parity_bytes)
    );

    assign o_stall         = !s1_ready;
    assign o_valid         = r_v2;
    assign o_block_end_out = r_end2;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && i_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted beat lost from product stage");

    a_stage1_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load |=> (o_valid && (o_block_end_out == $past(r_end1))))
        else $error("product stage beat not moved to output");

    a_out_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && i_stall) |=> (r_v2 && $stable(r_end2)))
        else $error("output beat dropped under stall");

endmodule
